// File: rtl/gmbc_pkg.sv
// shared types and constants for the gilbert-moore block codeword encoder
// no dependencies
`default_nettype none

package gmbc_pkg;

    localparam int PROB_W     = 16;
    localparam int BLK_LEN_W  = 4;
    localparam int CODE_W     = 32;
    localparam int SUM_W      = 33;
    localparam int CFG_ADDR_W = 2;
    localparam int MSB_W      = 5;
    localparam int STEP_W     = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_PROB_ZERO    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROB_ONE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH = 2'd2;

    localparam logic [PROB_W-1:0]    PROB_ZERO_RST    = 16'd26214;
    localparam logic [PROB_W-1:0]    PROB_ONE_RST     = 16'd39322;
    localparam logic [BLK_LEN_W-1:0] BLOCK_LENGTH_RST = 4'd1;

    // probability of an empty block, 1.0 in q1.32
    localparam logic [SUM_W-1:0] PROB_UNITY = 33'h1_0000_0000;

    // binary msb search: shifts of 16, 8, 4, 2, 1
    localparam logic [MSB_W-1:0]  NORM_FIRST_SHIFT = 5'd16;
    localparam logic [STEP_W-1:0] NORM_LAST_STEP   = 3'd4;

    // length offset: floor(-log2 p) + 2 = 34 - ceil(log2 p_q32)
    localparam logic [6:0] LEN_OFFSET = 7'd34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_LEN,
        ST_CODE,
        ST_DONE
    } gmbc_state_t;

    typedef struct packed {
        logic start;
        logic restart;
        logic take;
    } gmbc_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } gmbc_stat_t;

endpackage

`default_nettype wire

// File: rtl/gilbert_moore_block_codeword.sv
// top level of the gilbert-moore block codeword encoder: config registers,
// stream handshake and output register; depends on gmbc_pkg and gmbc_engine
//
// usage
//   s_* stream: one beat per source block; s_tdata carries the block bits
//   (first source bit most significant), s_tuser the restart flag that
//   clears the running probability sum before this block
//   m_* stream: one beat per block with the codeword and its length
//   cfg_*: register writes (prob_zero, prob_one, block_length); the user must
//   do them only while the block is idle, the block does not enforce it
// timing
//   a block of k bits, once accepted, runs k steps of the shared multiplier,
//   one per source bit, then five steps of the msb search, then the length,
//   codeword and hand-off states before its result is in the output register
//   one block is in work at a time; s_tready is high only while the
//   sequencer is idle, so the next block waits until the last is handed off
// reset and stall
//   reset clears the running sum, loads the register defaults and empties
//   the output register; a stalled result waits in the output register while
//   the next block is worked on, and that block waits in turn until the
//   register frees up
`default_nettype none

module gilbert_moore_block_codeword #(
    parameter int MAX_BLOCK_LEN = 10,
    parameter int MAX_CODE_LEN  = 32,
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1),
    localparam int IN_W         = ((MAX_BLOCK_LEN + 7) / 8) * 8,
    localparam int OUT_W        = ((gmbc_pkg::CODE_W + LEN_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,   // block_value
    input  logic                            s_tuser,   // restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,   // code_bits, code_length
    input  logic                            cfg_we,
    input  logic [gmbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gmbc_pkg::PROB_W-1:0]     cfg_wdata
);
    import gmbc_pkg::*;

    localparam int PAD_W = OUT_W - CODE_W - LEN_W;

    logic [PROB_W-1:0]    prob_zero_reg;
    logic [PROB_W-1:0]    prob_one_reg;
    logic [BLK_LEN_W-1:0] block_length_reg;

    logic                 m_valid_reg;
    logic [CODE_W-1:0]    out_code_reg;
    logic [LEN_W-1:0]     out_len_reg;

    gmbc_ctrl_t           ctrl;
    gmbc_stat_t           stat;
    logic [CODE_W-1:0]    eng_code;
    logic [LEN_W-1:0]     eng_len;
    logic                 out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_zero_reg    <= PROB_ZERO_RST;
            prob_one_reg     <= PROB_ONE_RST;
            block_length_reg <= BLOCK_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PROB_ZERO:    prob_zero_reg    <= cfg_wdata;
                REG_PROB_ONE:     prob_one_reg     <= cfg_wdata;
                REG_BLOCK_LENGTH: block_length_reg <= cfg_wdata[BLK_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free     = !m_valid_reg || m_tready;
    assign s_tready     = stat.idle;
    assign ctrl.start   = s_tvalid && stat.idle;
    assign ctrl.restart = s_tuser;
    assign ctrl.take    = stat.done && out_free;

    gmbc_engine #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .LEN_W         (LEN_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .block_value  (s_tdata[MAX_BLOCK_LEN-1:0]),
        .block_length (block_length_reg),
        .prob_zero    (prob_zero_reg),
        .prob_one     (prob_one_reg),
        .stat         (stat),
        .code_bits    (eng_code),
        .code_length  (eng_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ctrl.take)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            out_code_reg <= eng_code;
            out_len_reg  <= eng_len;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_len_reg, out_code_reg};

endmodule

`default_nettype wire

// File: rtl/gmbc_engine.sv
// sequenced datapath: shared multiplier for the block probability, msb search,
// code length, codeword shift and running sum; depends on gmbc_pkg
`default_nettype none

module gmbc_engine #(
    parameter int MAX_BLOCK_LEN = 10,
    parameter int MAX_CODE_LEN  = 32,
    parameter int LEN_W         = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gmbc_pkg::gmbc_ctrl_t             ctrl,
    input  logic [MAX_BLOCK_LEN-1:0]         block_value,
    input  logic [gmbc_pkg::BLK_LEN_W-1:0]   block_length,
    input  logic [gmbc_pkg::PROB_W-1:0]      prob_zero,
    input  logic [gmbc_pkg::PROB_W-1:0]      prob_one,
    output gmbc_pkg::gmbc_stat_t             stat,
    output logic [gmbc_pkg::CODE_W-1:0]      code_bits,
    output logic [LEN_W-1:0]                 code_length
);
    import gmbc_pkg::*;

    localparam int PROD_W = SUM_W + PROB_W;

    gmbc_state_t state_reg, state_next;

    logic [SUM_W-1:0]         p_reg;
    logic [MAX_BLOCK_LEN-1:0] bits_reg;
    logic [BLK_LEN_W-1:0]     cnt_reg;
    logic [CODE_W-1:0]        x_reg;
    logic [MSB_W-1:0]         msb_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CODE_W-1:0]        frac_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [CODE_W-1:0]        code_reg;

    logic [BLK_LEN_W-1:0]     k_eff;
    logic [4:0]               align_sh;
    logic [PROB_W-1:0]        factor;
    logic [PROD_W-1:0]        prod;
    logic [SUM_W-1:0]         p_mul;
    logic [MSB_W-1:0]         norm_sh;
    logic [CODE_W-1:0]        x_hi;
    logic [CODE_W-1:0]        p32;
    logic                     p_zero;
    logic                     p_pow2;
    logic [5:0]               c_ceil;
    logic [6:0]               raw_len;
    logic [6:0]               len_sat;
    logic [CODE_W-1:0]        frac_sum;
    logic [2*CODE_W-1:0]      code_wide;

    // block length clamp and alignment of the first source bit to the top
    always_comb
    begin
        if (block_length == '0)
            k_eff = BLK_LEN_W'(1);
        else if ({1'b0, block_length} > 5'(MAX_BLOCK_LEN))
            k_eff = BLK_LEN_W'(MAX_BLOCK_LEN);
        else
            k_eff = block_length;
        align_sh = 5'(MAX_BLOCK_LEN) - {1'b0, k_eff};
    end

    // shared multiplier, q1.32 times q0.16, truncated
    assign factor = bits_reg[MAX_BLOCK_LEN-1] ? prob_one : prob_zero;
    assign prod   = {{PROB_W{1'b0}}, p_reg} * {{SUM_W{1'b0}}, factor};
    assign p_mul  = prod[PROD_W-1:PROB_W];

    // msb search step
    assign norm_sh = NORM_FIRST_SHIFT >> step_reg;
    assign x_hi    = x_reg >> norm_sh;

    // code length
    assign p32     = p_reg[CODE_W-1:0];
    assign p_zero  = (p32 == '0);
    assign p_pow2  = ((p32 & (p32 - 32'd1)) == '0);
    assign c_ceil  = {1'b0, msb_reg} + {5'd0, ~p_pow2};
    assign raw_len = LEN_OFFSET - {1'b0, c_ceil};
    assign len_sat = (p_zero || (raw_len > 7'(MAX_CODE_LEN))) ? 7'(MAX_CODE_LEN) : raw_len;

    // sum plus half the probability, fractional bits only
    assign frac_sum  = sum_reg[CODE_W-1:0] + p_reg[SUM_W-1:1];
    assign code_wide = {frac_reg, {CODE_W{1'b0}}} >> (7'd64 - 7'(len_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == BLK_LEN_W'(1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (step_reg == NORM_LAST_STEP)
                    state_next = ST_LEN;
            end
            ST_LEN:  state_next = ST_CODE;
            ST_CODE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (ctrl.take)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        stat.idle = (state_reg == ST_IDLE);
        stat.done = (state_reg == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        cnt_reg <= k_eff;
                        if (ctrl.restart)
                            sum_reg <= '0;
                    end
                end
                ST_MUL:
                begin
                    cnt_reg  <= cnt_reg - BLK_LEN_W'(1);
                    step_reg <= '0;
                end
                ST_NORM: step_reg <= step_reg + STEP_W'(1);
                ST_CODE: sum_reg  <= sum_reg + p_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    p_reg    <= PROB_UNITY;
                    bits_reg <= block_value << align_sh;
                end
            end
            ST_MUL:
            begin
                p_reg    <= p_mul;
                bits_reg <= bits_reg << 1;
                x_reg    <= p_mul[CODE_W-1:0];
                msb_reg  <= '0;
            end
            ST_NORM:
            begin
                if (x_hi != '0)
                begin
                    x_reg   <= x_hi;
                    msb_reg <= msb_reg + norm_sh;
                end
            end
            ST_LEN:
            begin
                len_reg  <= LEN_W'(len_sat);
                frac_reg <= frac_sum;
            end
            ST_CODE: code_reg <= code_wide[CODE_W-1:0];
            default: ;
        endcase
    end

    assign code_bits   = code_reg;
    assign code_length = len_reg;

endmodule

`default_nettype wire

// File: rtl/gmbc_checker.sv
// port-level checks for gilbert_moore_block_codeword, bound to the top level
// depends on gmbc_pkg
`default_nettype none

module gmbc_checker #(
    parameter int MAX_BLOCK_LEN = 10,
    parameter int MAX_CODE_LEN  = 32,
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1),
    localparam int OUT_W        = ((gmbc_pkg::CODE_W + LEN_W + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import gmbc_pkg::*;

    logic [LEN_W-1:0] len_field;
    logic             in_beat;

    assign len_field = m_tdata[CODE_W +: LEN_W];
    assign in_beat   = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken again right after a beat");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after input");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (len_field >= LEN_W'(2)) && (len_field <= LEN_W'(MAX_CODE_LEN)))
        else $error("code length out of range");

endmodule

bind gilbert_moore_block_codeword gmbc_checker #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
) u_gmbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
